// ===== src/pba_pkg.sv =====
`default_nettype none
package pba_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int UNIT_BYTES   = 32;
  localparam int HEADER_BYTES = 16;
  localparam int NUM_UNITS    = POOL_BYTES / UNIT_BYTES;

  localparam int IDX_W   = $clog2(NUM_UNITS);
  localparam int UNITS_W = $clog2(NUM_UNITS + 1);
  localparam int NXT_W   = UNITS_W + 1;

  localparam int OPC_W   = 2;
  localparam int REQ_W   = 13;
  localparam int ADDR_W  = 12;
  localparam int STAT_W  = 2;
  localparam int NEED_W  = REQ_W + 2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 3;
  localparam int TAIL_W    = 3;

  localparam logic [OPC_W-1:0] OP_REQ  = 2'd0;
  localparam logic [OPC_W-1:0] OP_REL  = 2'd1;
  localparam logic [OPC_W-1:0] OP_INIT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADREL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BEST_FIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL     = 1'd1;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] release_address;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] payload_address;
  } out_t;

  typedef struct packed {
    logic               start;
    logic               free;
    logic [UNITS_W-1:0] units;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_ROOT = '{start: 1'b1, free: 1'b1,
                                    units: UNITS_W'(NUM_UNITS)};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_M_A,
    S_M_CHK,
    S_M_B,
    S_M_W2,
    S_ALLOC,
    S_SPLIT,
    S_REL
  } state_e;

endpackage
`default_nettype wire

// ===== src/pba_ram.sv =====
`default_nettype none
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/pool_block_allocator.sv =====
`default_nettype none
// Unit-granular pool allocator. Raise start_i for one cycle while busy_o is
// low; exactly one result word follows on res_o, marked by a one-cycle done_o
// strobe in the cycle after the operation finishes, and must be taken then.
// Block state sits in one single-port RAM entry per unit (start, free, length)
// with a per-entry valid flop, so reinit only clears the valid flops and no
// clearing pass is needed after reset. A release passes through S_REL alone;
// reinit, a bad release address and an unknown opcode answer from idle and
// never raise busy_o. A request walks the block chain at one block per cycle
// (at most 128); if nothing fits, one merge pass joins free neighbours (S_M_A,
// then S_M_CHK and S_M_B per block, plus S_M_W2 per merged pair) and the walk
// repeats once; allocation writes in S_ALLOC and, on a split, in S_SPLIT.
module pool_block_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire pba_pkg::in_t                    item_i,
  output logic                                 done_o,
  output pba_pkg::out_t                        res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pba_pkg::CFG_W-1:0]       cfg_data_i
);
  import pba_pkg::*;

  state_e state_q, state_d;
  logic              mode_q;
  logic [TAIL_W-1:0] tail_q;
  logic [IDX_W-1:0]  u_q, u_d, n_q, n_d, best_q, best_d;
  logic [UNITS_W-1:0] best_len_q, best_len_d;
  logic              best_v_q, best_v_d, merged_q, merged_d;
  logic [NEED_W-1:0] need_q, need_d;
  entry_t            a_q, a_d;
  logic [NUM_UNITS-1:0] valid_q;
  logic              clr_valid;
  logic              done_q, done_d;
  out_t              res_q, res_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr, rd_idx_q;
  entry_t            ram_wdata, ram_rdata, rd_entry;

  pba_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_UNITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // entries never written since reinit read as the fresh pool
  always_comb begin
    if (valid_q[rd_idx_q]) begin
      rd_entry = ram_rdata;
    end else if (rd_idx_q == '0) begin
      rd_entry = ENTRY_ROOT;
    end else begin
      rd_entry = '0;
    end
  end

  logic [NEED_W-1:0] total, rounded, need_calc;
  logic [ADDR_W-1:0] rel_off;
  logic [ADDR_W-1:0] rel_div;
  logic              rel_bad;
  logic [NXT_W-1:0]  nxt;
  logic              fit, take, hit, last_blk, split;
  logic              bv;
  logic [IDX_W-1:0]  b;
  logic [UNITS_W-1:0] bl;

  always_comb begin
    total     = NEED_W'(item_i.request_bytes) + NEED_W'(HEADER_BYTES);
    rounded   = NEED_W'((total + NEED_W'(UNIT_BYTES - 1)) / UNIT_BYTES);
    need_calc = rounded + NEED_W'(tail_q);
    if (need_calc == '0) begin
      need_calc = NEED_W'(1);
    end
    rel_off = item_i.release_address - ADDR_W'(HEADER_BYTES);
    rel_div = ADDR_W'(rel_off / UNIT_BYTES);
    rel_bad = (item_i.release_address < ADDR_W'(HEADER_BYTES)) ||
              ((rel_off % UNIT_BYTES) != 0) ||
              (32'(rel_div) >= NUM_UNITS);
  end

  always_comb begin
    state_d    = state_q;
    u_d        = u_q;
    n_d        = n_q;
    best_d     = best_q;
    best_len_d = best_len_q;
    best_v_d   = best_v_q;
    merged_d   = merged_q;
    need_d     = need_q;
    a_d        = a_q;
    clr_valid  = 1'b0;
    done_d     = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_addr   = u_q;
    ram_wdata  = '0;
    nxt        = NXT_W'(u_q) + NXT_W'(rd_entry.units);
    fit        = 1'b0;
    take       = 1'b0;
    hit        = 1'b0;
    last_blk   = 1'b0;
    split      = 1'b0;
    bv         = best_v_q;
    b          = best_q;
    bl         = best_len_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.opcode)
            OP_REQ: begin
              need_d   = need_calc;
              u_d      = '0;
              best_v_d = 1'b0;
              merged_d = 1'b0;
              ram_addr = '0;
              state_d  = S_SRCH;
            end
            OP_REL: begin
              if (rel_bad) begin
                done_d = 1'b1;
                res_d  = '{status: ST_BADREL, payload_address: '0};
              end else begin
                u_d      = rel_div[IDX_W-1:0];
                ram_addr = rel_div[IDX_W-1:0];
                state_d  = S_REL;
              end
            end
            OP_INIT: begin
              clr_valid = 1'b1;
              done_d    = 1'b1;
              res_d     = '{status: ST_OK, payload_address: '0};
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{status: ST_OK, payload_address: '0};
            end
          endcase
        end
      end

      S_SRCH: begin
        fit  = rd_entry.start && rd_entry.free &&
               (NEED_W'(rd_entry.units) >= need_q);
        take = fit && (!mode_q || !best_v_q || (rd_entry.units < best_len_q));
        if (take) begin
          bv = 1'b1;
          b  = u_q;
          bl = rd_entry.units;
        end
        hit      = take && (!mode_q || (NEED_W'(rd_entry.units) == need_q));
        last_blk = (rd_entry.units == '0) || (32'(nxt) >= NUM_UNITS);
        best_v_d   = bv;
        best_d     = b;
        best_len_d = bl;
        if (hit || (last_blk && bv)) begin
          state_d = S_ALLOC;
        end else if (last_blk) begin
          if (!merged_q) begin
            u_d      = '0;
            ram_addr = '0;
            state_d  = S_M_A;
          end else begin
            done_d  = 1'b1;
            res_d   = '{status: ST_NOFIT, payload_address: '0};
            state_d = S_IDLE;
          end
        end else begin
          u_d      = nxt[IDX_W-1:0];
          ram_addr = nxt[IDX_W-1:0];
        end
      end

      S_M_A: begin
        a_d     = rd_entry;
        state_d = S_M_CHK;
      end

      S_M_CHK: begin
        nxt = NXT_W'(u_q) + NXT_W'(a_q.units);
        if ((a_q.units == '0) || (32'(nxt) >= NUM_UNITS)) begin
          // merge done: walk again from the pool start
          merged_d = 1'b1;
          best_v_d = 1'b0;
          u_d      = '0;
          ram_addr = '0;
          state_d  = S_SRCH;
        end else begin
          n_d      = nxt[IDX_W-1:0];
          ram_addr = nxt[IDX_W-1:0];
          state_d  = S_M_B;
        end
      end

      S_M_B: begin
        if (a_q.free && rd_entry.free) begin
          ram_we    = 1'b1;
          ram_addr  = u_q;
          a_d.units = a_q.units + rd_entry.units;
          ram_wdata = '{start: 1'b1, free: 1'b1, units: a_q.units + rd_entry.units};
          state_d   = S_M_W2;
        end else begin
          u_d     = n_q;
          a_d     = rd_entry;
          state_d = S_M_CHK;
        end
      end

      S_M_W2: begin
        ram_we    = 1'b1;
        ram_addr  = n_q;
        ram_wdata = '0;
        state_d   = S_M_CHK;
      end

      S_ALLOC: begin
        split     = NEED_W'(best_len_q) > need_q;
        ram_we    = 1'b1;
        ram_addr  = best_q;
        ram_wdata = '{start: 1'b1, free: 1'b0,
                      units: split ? need_q[UNITS_W-1:0] : best_len_q};
        res_d     = '{status: ST_OK,
                      payload_address: ADDR_W'(32'(best_q) * UNIT_BYTES + HEADER_BYTES)};
        if (split) begin
          state_d = S_SPLIT;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_addr  = best_q + need_q[IDX_W-1:0];
        ram_wdata = '{start: 1'b1, free: 1'b1,
                      units: best_len_q - need_q[UNITS_W-1:0]};
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_REL: begin
        if (rd_entry.start && !rd_entry.free) begin
          ram_we    = 1'b1;
          ram_addr  = u_q;
          ram_wdata = '{start: 1'b1, free: 1'b1, units: rd_entry.units};
          res_d     = '{status: ST_OK, payload_address: '0};
        end else begin
          res_d     = '{status: ST_BADREL, payload_address: '0};
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= 1'b0;
      tail_q   <= '0;
      valid_q  <= '0;
      done_q   <= 1'b0;
      best_v_q <= 1'b0;
      merged_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      best_v_q <= best_v_d;
      merged_q <= merged_d;
      if (clr_valid) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[ram_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BEST_FIT: mode_q <= cfg_data_i[0];
          CFG_TAIL:     tail_q <= cfg_data_i[TAIL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    n_q        <= n_d;
    best_q     <= best_d;
    best_len_q <= best_len_d;
    need_q     <= need_d;
    a_q        <= a_d;
    res_q      <= res_d;
    if (!ram_we) begin
      rd_idx_q <= ram_addr;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_init_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.opcode == OP_INIT)) |=>
      (done_o && (res_o.status == ST_OK) && (valid_q == '0)))
    else $error("reinit did not answer at once");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |-> (res_o.payload_address == '0))
    else $error("failed word carries an address");

  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("pool write while idle");

endmodule
`default_nettype wire
